// ===== rtl/lcp_pkg.sv =====
package lcp_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_CONNECT = 3'd0;
  localparam logic [2:0] OP_SAMPLE  = 3'd1;
  localparam logic [2:0] OP_PHASE   = 3'd2;
  localparam logic [2:0] OP_FAULT   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;
  localparam logic [2:0] OP_ABORT   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_GAP_LIMIT      = 2'd0;
  localparam logic [1:0] CFG_CONFIRM        = 2'd1;
  localparam logic [1:0] CFG_DURATION       = 2'd2;
  localparam logic [1:0] CFG_PROBE_DISABLED = 2'd3;

  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [15:0] GAP_LIMIT_RST = 16'd1000;
  localparam logic [7:0]  CONFIRM_RST   = 8'd10;
  localparam logic [19:0] DURATION_RST  = 20'd10000;

  localparam logic [7:0]  RUN_MAX   = 8'hFF;
  localparam logic [15:0] FAULT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_CONFIRMING = 3'd1,
    MODE_ARMED      = 3'd2,
    MODE_PROBING    = 3'd3,
    MODE_DONE       = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REASON_SCALE_GONE   = 3'd0,
    REASON_SHOT_STARTED = 3'd1,
    REASON_PROVOKED     = 3'd2,
    REASON_LINK_DOWN    = 3'd3,
    REASON_LEFT_IDLE    = 3'd4,
    REASON_TIMEOUT      = 3'd5,
    REASON_ABORT        = 3'd6
  } reason_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now_ms;
    logic        scale_connected;
    logic        machine_idle;
    logic        host_link_up;
    logic        backoff_latched;
  } in_item_t;

  typedef struct packed {
    mode_t       mode;
    logic        probe_started;
    logic        probe_ended;
    reason_t     end_reason;
    logic        provoked;
    logic [15:0] faults_in_window;
    logic        issue_burst;
  } out_item_t;

  typedef struct packed {
    logic [15:0] gap_limit_ms;
    logic [7:0]  confirm_samples;
    logic [19:0] probe_duration_ms;
    logic        probe_disabled;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  sample_run;
    logic [31:0] last_sample_ms;
    logic [31:0] window_start_ms;
    logic [15:0] fault_count;
    logic        latched_at_start;
  } state_t;

endpackage

// ===== rtl/lcp_step.sv =====
module lcp_step (
  input  lcp_pkg::in_item_t  item,
  input  lcp_pkg::state_t    st,
  input  lcp_pkg::cfg_t      cfg,
  output lcp_pkg::state_t    st_next,
  output lcp_pkg::out_item_t res
);

  logic [31:0] gap;
  logic        gap_over;
  logic [7:0]  run_inc;
  logic [31:0] elapsed;
  logic        timed_out;
  logic        provoke;
  logic        dur_zero;
  logic        do_start;

  // gap to the previous sample, zero when no sample was seen yet
  assign gap       = (|st.last_sample_ms) ? (item.now_ms - st.last_sample_ms) : 32'd0;
  assign gap_over  = gap > {16'd0, cfg.gap_limit_ms};
  assign run_inc   = (st.sample_run != lcp_pkg::RUN_MAX) ? (st.sample_run + 8'd1)
                                                          : st.sample_run;
  assign elapsed   = item.now_ms - st.window_start_ms;
  assign timed_out = elapsed >= {12'd0, cfg.probe_duration_ms};
  assign provoke   = item.backoff_latched && !st.latched_at_start;
  assign dur_zero  = ~|cfg.probe_duration_ms;

  always_comb begin
    st_next  = st;
    res      = '0;
    do_start = 1'b0;
    case (item.operation)
      lcp_pkg::OP_CONNECT: begin
        if (item.scale_connected) begin
          if (st.mode == lcp_pkg::MODE_IDLE) begin
            st_next.mode           = lcp_pkg::MODE_CONFIRMING;
            st_next.sample_run     = '0;
            st_next.last_sample_ms = '0;
          end
        end else begin
          if (st.mode == lcp_pkg::MODE_PROBING) begin
            res.probe_ended = 1'b1;
            res.end_reason  = lcp_pkg::REASON_SCALE_GONE;
            res.provoked    = provoke;
          end
          st_next.mode           = lcp_pkg::MODE_IDLE;
          st_next.sample_run     = '0;
          st_next.last_sample_ms = '0;
        end
      end
      lcp_pkg::OP_SAMPLE: begin
        st_next.last_sample_ms = item.now_ms;
        if (st.mode == lcp_pkg::MODE_CONFIRMING) begin
          if (gap_over) begin
            st_next.sample_run = 8'd1;
          end else begin
            st_next.sample_run = run_inc;
            if (run_inc >= cfg.confirm_samples) begin
              st_next.mode = lcp_pkg::MODE_ARMED;
              do_start     = 1'b1;
            end
          end
        end
      end
      lcp_pkg::OP_PHASE: begin
        if (st.mode == lcp_pkg::MODE_PROBING && !item.machine_idle) begin
          st_next.mode    = lcp_pkg::MODE_DONE;
          res.probe_ended = 1'b1;
          res.end_reason  = lcp_pkg::REASON_SHOT_STARTED;
          res.provoked    = provoke;
        end else if (st.mode == lcp_pkg::MODE_ARMED && item.machine_idle) begin
          do_start = 1'b1;
        end
      end
      lcp_pkg::OP_FAULT: begin
        if (st.mode == lcp_pkg::MODE_PROBING && st.fault_count != lcp_pkg::FAULT_MAX) begin
          st_next.fault_count = st.fault_count + 16'd1;
        end
      end
      lcp_pkg::OP_TICK: begin
        if (st.mode == lcp_pkg::MODE_PROBING) begin
          if (provoke || !item.host_link_up || !item.machine_idle || timed_out) begin
            st_next.mode    = lcp_pkg::MODE_DONE;
            res.probe_ended = 1'b1;
            res.provoked    = provoke;
            if (provoke) begin
              res.end_reason = lcp_pkg::REASON_PROVOKED;
            end else if (!item.host_link_up) begin
              res.end_reason = lcp_pkg::REASON_LINK_DOWN;
            end else if (!item.machine_idle) begin
              res.end_reason = lcp_pkg::REASON_LEFT_IDLE;
            end else begin
              res.end_reason = lcp_pkg::REASON_TIMEOUT;
            end
          end else begin
            res.issue_burst = 1'b1;
          end
        end
      end
      lcp_pkg::OP_ABORT: begin
        if (st.mode == lcp_pkg::MODE_PROBING) begin
          st_next.mode    = lcp_pkg::MODE_DONE;
          res.probe_ended = 1'b1;
          res.end_reason  = lcp_pkg::REASON_ABORT;
          res.provoked    = provoke;
        end
      end
      default: begin
      end
    endcase

    // probe start with its immediate first tick; latch is clear here
    if (do_start && !cfg.probe_disabled && item.host_link_up && item.machine_idle) begin
      if (item.backoff_latched) begin
        st_next.mode = lcp_pkg::MODE_DONE;
      end else begin
        st_next.mode             = lcp_pkg::MODE_PROBING;
        st_next.latched_at_start = 1'b0;
        st_next.fault_count      = '0;
        st_next.window_start_ms  = item.now_ms;
        res.probe_started        = 1'b1;
        if (dur_zero) begin
          st_next.mode    = lcp_pkg::MODE_DONE;
          res.probe_ended = 1'b1;
          res.end_reason  = lcp_pkg::REASON_TIMEOUT;
        end else begin
          res.issue_burst = 1'b1;
        end
      end
    end

    res.mode             = st_next.mode;
    res.faults_in_window = st_next.fault_count;
  end

endmodule

// ===== rtl/link_contention_probe_fsm_core.sv =====
// Link contention probe supervisor. Every input item (connect change, sample, phase change,
// link fault, tick or abort) produces exactly one result item with the mode after the event,
// start/end flags of the probe window, the end reason, the provoked flag, the saturating
// fault count and a read-burst request. Items are taken one per clock cycle while in_stall is low:
// each item lands in an input register, and one pass of compare/increment logic updates the
// supervisor state and fills the result register, from which the result is offered. A result
// stalled in the output register holds the next item in the input register, and the input
// stalls once both registers are full. Configuration registers are to be written through
// cfg_we/cfg_index/cfg_data by the user only while no item is in flight; the block itself
// does not enforce this.
module link_contention_probe_fsm_core (
  input  logic                               clk,
  input  logic                               rst,
  // input item channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lcp_pkg::in_item_t                  in_item,
  // result item channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output lcp_pkg::out_item_t                 out_item,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [lcp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lcp_pkg::cfg_t      cfg;
  lcp_pkg::state_t    st;
  lcp_pkg::state_t    st_next;
  lcp_pkg::in_item_t  s1_item;
  logic               s1_valid;
  logic               s1_advance;
  logic               s1_load;
  lcp_pkg::out_item_t res;

  // the held item moves on whenever the result register is empty or being drained
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign s1_load    = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_limit_ms      <= lcp_pkg::GAP_LIMIT_RST;
      cfg.confirm_samples   <= lcp_pkg::CONFIRM_RST;
      cfg.probe_duration_ms <= lcp_pkg::DURATION_RST;
      cfg.probe_disabled    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcp_pkg::CFG_GAP_LIMIT:      cfg.gap_limit_ms      <= cfg_data[15:0];
        lcp_pkg::CFG_CONFIRM:        cfg.confirm_samples   <= cfg_data[7:0];
        lcp_pkg::CFG_DURATION:       cfg.probe_duration_ms <= cfg_data[19:0];
        lcp_pkg::CFG_PROBE_DISABLED: cfg.probe_disabled    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= in_item;
    end
  end

  // one event's state update and result
  lcp_step u_step (
    .item    (s1_item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  // supervisor state, committed as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode             <= lcp_pkg::MODE_IDLE;
      st.sample_run       <= '0;
      st.last_sample_ms   <= '0;
      st.window_start_ms  <= '0;
      st.fault_count      <= '0;
      st.latched_at_start <= 1'b0;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_item <= res;
    end
  end

  // a window end leaves the block in done, or in idle when the scale went away
  a_end_is_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.probe_ended |->
      (out_item.mode == lcp_pkg::MODE_DONE || out_item.mode == lcp_pkg::MODE_IDLE))
    else $error("probe end outside done or idle mode");

  // a burst request only while the window stays open
  a_burst_probing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.issue_burst |->
      out_item.mode == lcp_pkg::MODE_PROBING && !out_item.probe_ended)
    else $error("burst outside an open window");

  // provoked is reported only on a window end
  a_provoked_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.provoked |-> out_item.probe_ended)
    else $error("provoked without window end");

  // state follows the mode of the last delivered item
  a_mode_match: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_item.mode == st.mode)
    else $error("result mode differs from state");

  // the input side never stalls while its register is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("stall with empty input register");

endmodule

// ===== tb/sv/link_contention_probe_fsm_core_test.sv =====
`timescale 1ns / 1ps

class probe_supervisor_model;
  logic [15:0] gap_limit;
  logic [7:0]  confirm_need;
  logic [19:0] duration;
  logic        disabled;

  lcp_pkg::mode_t     mode;
  logic [7:0]  run_len;
  logic [31:0] last_sample;
  logic [31:0] window_start;
  logic [15:0] faults;
  logic        latch_at_start;

  lcp_pkg::out_item_t res;
  lcp_pkg::out_item_t awaited_reports[$];
  int unsigned failures;

  function new();
    gap_limit = lcp_pkg::GAP_LIMIT_RST;
    confirm_need = lcp_pkg::CONFIRM_RST;
    duration = lcp_pkg::DURATION_RST;
    disabled = 1'b0;
    mode = lcp_pkg::MODE_IDLE;
    run_len = '0;
    last_sample = '0;
    window_start = '0;
    faults = '0;
    latch_at_start = 1'b0;
    failures = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [lcp_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      lcp_pkg::CFG_GAP_LIMIT: gap_limit = val[15:0];
      lcp_pkg::CFG_CONFIRM: confirm_need = val[7:0];
      lcp_pkg::CFG_DURATION: duration = val[19:0];
      lcp_pkg::CFG_PROBE_DISABLED: disabled = val[0];
      default: ;
    endcase
  endfunction

  function void close_window(lcp_pkg::reason_t why, logic latch);
    if (mode != lcp_pkg::MODE_PROBING) return;
    mode = lcp_pkg::MODE_DONE;
    res.probe_ended = 1'b1;
    res.end_reason = why;
    res.provoked = latch && !latch_at_start;
  endfunction

  function void run_tick(logic [31:0] now, logic idle, logic link, logic latch);
    logic [31:0] elapsed;
    elapsed = now - window_start;
    if (mode != lcp_pkg::MODE_PROBING) return;
    if (latch && !latch_at_start) close_window(lcp_pkg::REASON_PROVOKED, latch);
    else if (!link) close_window(lcp_pkg::REASON_LINK_DOWN, latch);
    else if (!idle) close_window(lcp_pkg::REASON_LEFT_IDLE, latch);
    else if (elapsed >= 32'(duration)) close_window(lcp_pkg::REASON_TIMEOUT, latch);
    else res.issue_burst = 1'b1;
  endfunction

  function void try_start(logic [31:0] now, logic idle, logic link, logic latch);
    if (mode != lcp_pkg::MODE_ARMED || disabled || !link || !idle) return;
    if (latch) begin
      // latch already set at arming: nothing to provoke
      mode = lcp_pkg::MODE_DONE;
      return;
    end
    mode = lcp_pkg::MODE_PROBING;
    latch_at_start = latch;
    faults = '0;
    window_start = now;
    res.probe_started = 1'b1;
    run_tick(now, idle, link, latch);
  endfunction

  function void note_event(lcp_pkg::in_item_t it);
    logic [31:0] gap;
    res = '0;
    case (it.operation)
      lcp_pkg::OP_CONNECT: begin
        if (it.scale_connected) begin
          if (mode == lcp_pkg::MODE_IDLE) begin
            mode = lcp_pkg::MODE_CONFIRMING;
            run_len = '0;
            last_sample = '0;
          end
        end else begin
          close_window(lcp_pkg::REASON_SCALE_GONE, it.backoff_latched);
          mode = lcp_pkg::MODE_IDLE;
          run_len = '0;
          last_sample = '0;
        end
      end
      lcp_pkg::OP_SAMPLE: begin
        // a stored zero stamp means no sample yet
        gap = (last_sample != 0) ? it.now_ms - last_sample : 32'd0;
        last_sample = it.now_ms;
        if (mode == lcp_pkg::MODE_CONFIRMING) begin
          if (gap > 32'(gap_limit)) begin
            run_len = 8'd1;
          end else begin
            if (run_len < lcp_pkg::RUN_MAX) run_len = run_len + 8'd1;
            if (run_len >= confirm_need) begin
              mode = lcp_pkg::MODE_ARMED;
              try_start(it.now_ms, it.machine_idle, it.host_link_up, it.backoff_latched);
            end
          end
        end
      end
      lcp_pkg::OP_PHASE: begin
        if (mode == lcp_pkg::MODE_PROBING && !it.machine_idle)
          close_window(lcp_pkg::REASON_SHOT_STARTED, it.backoff_latched);
        else if (mode == lcp_pkg::MODE_ARMED && it.machine_idle)
          try_start(it.now_ms, it.machine_idle, it.host_link_up, it.backoff_latched);
      end
      lcp_pkg::OP_FAULT: begin
        if (mode == lcp_pkg::MODE_PROBING && faults < lcp_pkg::FAULT_MAX)
          faults = faults + 16'd1;
      end
      lcp_pkg::OP_TICK:
        run_tick(it.now_ms, it.machine_idle, it.host_link_up, it.backoff_latched);
      lcp_pkg::OP_ABORT: close_window(lcp_pkg::REASON_ABORT, it.backoff_latched);
      default: ;
    endcase
    res.mode = mode;
    res.faults_in_window = faults;
    awaited_reports.push_back(res);
  endfunction

  function string describe(lcp_pkg::out_item_t r);
    return $sformatf("mode=%0d started=%0b ended=%0b reason=%0d provoked=%0b faults=%0d burst=%0b",
                     r.mode, r.probe_started, r.probe_ended, r.end_reason, r.provoked,
                     r.faults_in_window, r.issue_burst);
  endfunction

  function void check_report(lcp_pkg::out_item_t got);
    lcp_pkg::out_item_t want;
    if (awaited_reports.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected result item: %s", describe(got));
      return;
    end
    want = awaited_reports.pop_front();
    if (got.mode !== want.mode || got.probe_started !== want.probe_started ||
        got.probe_ended !== want.probe_ended || got.end_reason !== want.end_reason ||
        got.provoked !== want.provoked || got.faults_in_window !== want.faults_in_window ||
        got.issue_burst !== want.issue_burst) begin
      failures++;
      if (failures <= 10) begin
        $display("result mismatch at %0t", $time);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endfunction
endclass

module link_contention_probe_fsm_core_test;

  // spare operation codes, ignored by the block
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  lcp_pkg::in_item_t              in_item;
  logic                           out_valid;
  logic                           out_stall;
  lcp_pkg::out_item_t             out_item;
  logic                           cfg_we;
  logic [1:0]                     cfg_index;
  logic [lcp_pkg::CFG_DATA_W-1:0] cfg_data;

  probe_supervisor_model sb;

  // idling odds of the current phase, in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // a long receiver hold-off, picked up by the result sink
  int unsigned long_hold_cycles = 0;
  int unsigned sent_count = 0;
  // event timeline of the well-formed sessions, wraps freely
  logic [31:0] clock_ms;

  link_contention_probe_fsm_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // every accepted result item is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_report(out_item);
  end

  // result sink: random stalls, plus a long hold-off when one is requested
  initial begin : result_sink
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles != 0) begin
        n = long_hold_cycles;
        long_hold_cycles = 0;
        repeat (n) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // generous ceiling on the whole run
  initial begin : watchdog
    #4000000;
    $display("link_contention_probe_fsm_core_test NOT OK");
    $finish;
  end

  function automatic lcp_pkg::in_item_t pack_event(logic [2:0] op, logic [31:0] now,
                                                   logic conn, logic idle, logic link,
                                                   logic latch);
    lcp_pkg::in_item_t it;
    it.operation = op;
    it.now_ms = now;
    it.scale_connected = conn;
    it.machine_idle = idle;
    it.host_link_up = link;
    it.backoff_latched = latch;
    return it;
  endfunction

  // event on the session timeline; status is healthy unless upset
  function automatic lcp_pkg::in_item_t make_event(logic [2:0] op, logic conn,
                                                   int unsigned upset_pct);
    logic [2:0] status;
    status = ($urandom_range(99) < upset_pct) ? 3'($urandom) : 3'b110;
    return pack_event(op, clock_ms, conn, status[2], status[1], status[0]);
  endfunction

  // anything at all, spare codes and stray timestamps included
  function automatic lcp_pkg::in_item_t noise_event();
    logic [3:0] bits;
    bits = 4'($urandom);
    return pack_event(3'($urandom), $urandom, bits[3], bits[2], bits[1], bits[0]);
  endfunction

  // offer one item, hold it until taken, then log it with the predictor
  task automatic send_event(input lcp_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(it);
    sent_count++;
  endtask

  // sender goes quiet until every predicted result item has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [lcp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] gap, input logic [7:0] need,
                                input logic [19:0] dur, input logic dis);
    put_reg(lcp_pkg::CFG_GAP_LIMIT, lcp_pkg::CFG_DATA_W'(gap));
    put_reg(lcp_pkg::CFG_CONFIRM, lcp_pkg::CFG_DATA_W'(need));
    put_reg(lcp_pkg::CFG_DURATION, dur);
    put_reg(lcp_pkg::CFG_PROBE_DISABLED, lcp_pkg::CFG_DATA_W'(dis));
    cfg_we <= 1'b0;
  endtask

  // connect, samples until confirmed or confirm_need + 8 sent, then a burst of events
  task automatic probe_session(input int unsigned upset_pct);
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [31:0] advance;
    logic [2:0]  op;
    if ($urandom_range(9) != 0)
      send_event(make_event(lcp_pkg::OP_CONNECT, 1'b0, upset_pct));
    send_event(make_event(lcp_pkg::OP_CONNECT, 1'b1, upset_pct));
    n = 0;
    while (sb.mode == lcp_pkg::MODE_CONFIRMING && n < sb.confirm_need + 8) begin
      // now and then a gap too long, which restarts the run
      if ($urandom_range(19) == 0)
        advance = 32'(sb.gap_limit) + 32'd1 + 32'($urandom_range(5000));
      else
        advance = 32'($urandom_range(sb.gap_limit));
      clock_ms = clock_ms + advance;
      send_event(make_event(lcp_pkg::OP_SAMPLE, 1'($urandom), upset_pct));
      n++;
    end
    k = $urandom_range(1, 14);
    repeat (k) begin
      clock_ms = clock_ms + 32'($urandom_range(sb.duration / 3 + 1));
      pick = $urandom_range(99);
      if (pick < 50) op = lcp_pkg::OP_TICK;
      else if (pick < 72) op = lcp_pkg::OP_FAULT;
      else if (pick < 82) op = lcp_pkg::OP_PHASE;
      else if (pick < 88) op = lcp_pkg::OP_SAMPLE;
      else if (pick < 94) op = lcp_pkg::OP_ABORT;
      else op = lcp_pkg::OP_CONNECT;
      // phase changes are upset more often so that shots get started
      send_event(make_event(op, 1'($urandom), (op == lcp_pkg::OP_PHASE) ? 50 : upset_pct));
    end
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned first;
    first = sent_count;
    while (sent_count - first < quota) begin
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 4)) send_event(noise_event());
      else probe_session(($urandom_range(3) == 0) ? 40 : 8);
    end
  endtask

  initial begin : stimulus
    int unsigned send_pcts[4];
    int unsigned recv_pcts[4];
    send_pcts = '{0, 79, 0, 11};
    recv_pcts = '{0, 0, 79, 11};
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = lcp_pkg::CFG_GAP_LIMIT;
    cfg_data = '0;
    clock_ms = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short confirm so that each case is reached in a few items
    apply_settings(16'd1000, 8'd2, 20'd10000, 1'b0);
    // sample at time zero while idle, then one whose gap reads as zero
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'd0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1));
    // spare codes are ignored
    send_event(pack_event(OP_SPARE_LO, 32'h0000_1234, 1'b1, 1'b1, 1'b1, 1'b1));
    send_event(pack_event(OP_SPARE_HI, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
    // connect, a repeated connect is ignored
    send_event(pack_event(lcp_pkg::OP_CONNECT, 32'd100, 1'b1, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_CONNECT, 32'd110, 1'b1, 1'b1, 1'b1, 1'b0));
    // run broken by a long gap, then armed with the latch already set
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'd200, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'd1500, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'd2500, 1'b0, 1'b1, 1'b1, 1'b1));
    send_event(pack_event(lcp_pkg::OP_ABORT, 32'd2550, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_CONNECT, 32'd2600, 1'b0, 1'b1, 1'b1, 1'b0));
    // armed while busy, started by the phase change back to idle
    send_event(pack_event(lcp_pkg::OP_CONNECT, 32'd2700, 1'b1, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'd2800, 1'b0, 1'b0, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'd2900, 1'b0, 1'b0, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_PHASE, 32'd3000, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_FAULT, 32'd3100, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_FAULT, 32'd3200, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_TICK, 32'd5000, 1'b0, 1'b1, 1'b1, 1'b0));
    // shot started closes the window
    send_event(pack_event(lcp_pkg::OP_PHASE, 32'd6000, 1'b0, 1'b0, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_CONNECT, 32'd6100, 1'b0, 1'b1, 1'b1, 1'b1));
    // window opened just before the stamp wraps, timed out just after
    send_event(pack_event(lcp_pkg::OP_CONNECT, 32'd6200, 1'b1, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'hFFFF_FF00, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_SAMPLE, 32'hFFFF_FFF0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_TICK, 32'h0000_2700, 1'b0, 1'b1, 1'b1, 1'b0));
    send_event(pack_event(lcp_pkg::OP_CONNECT, 32'h0000_2800, 1'b0, 1'b1, 1'b1, 1'b0));
    wait_for_results();

    // a long window that collects a run of link faults
    apply_settings(16'd1000, 8'd1, 20'hFFFFF, 1'b0);
    send_event(make_event(lcp_pkg::OP_CONNECT, 1'b0, 0));
    send_event(make_event(lcp_pkg::OP_CONNECT, 1'b1, 0));
    send_event(make_event(lcp_pkg::OP_SAMPLE, 1'b0, 0));
    repeat (40) send_event(make_event(lcp_pkg::OP_FAULT, 1'b0, 0));
    send_event(make_event(lcp_pkg::OP_TICK, 1'b0, 0));
    send_event(make_event(lcp_pkg::OP_ABORT, 1'b0, 0));

    // random phases, each under its own settings and idling pattern
    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      case (p)
        0: apply_settings(16'd1000, 8'd3, 20'd5000, 1'b0);
        1: apply_settings(16'hFFFF, 8'hFF, 20'hFFFFF, 1'b0);
        2: apply_settings(16'd0, 8'd1, 20'd0, 1'b0);
        3: apply_settings(16'd200, 8'd2, 20'd3000, 1'b1);
        4: apply_settings(16'($urandom_range(50, 3000)), 8'($urandom_range(1, 6)),
                          20'($urandom_range(0, 20000)), 1'b0);
        default: apply_settings(16'($urandom_range(100, 2000)), 8'($urandom_range(0, 4)),
                                20'($urandom_range(1000, 8000)), 1'($urandom_range(3) == 0));
      endcase
      send_idle_pct = send_pcts[p % 4];
      recv_stall_pct = recv_pcts[p % 4];
      // receiver holds off while the sender keeps offering, so the block backs up
      if (p == 0) long_hold_cycles = 300;
      random_phase((p == 1) ? 300 : 280);
    end

    wait_for_results();
    if (sb.failures == 0 && sb.awaited_reports.size() == 0)
      $display("link_contention_probe_fsm_core_test OK");
    else
      $display("link_contention_probe_fsm_core_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lcp_pkg.sv
rtl/lcp_step.sv
rtl/link_contention_probe_fsm_core.sv
tb/sv/link_contention_probe_fsm_core_test.sv
